### hw/rtl/lpbte_pkg.sv
// ----------------------------------------------------------------------------
// lpbte_pkg
// Shared types, constants and correction curves of the LED pixel bit encoder.
// ----------------------------------------------------------------------------
package lpbte_pkg;

	localparam int BITS_PER_PIXEL = 24;
	localparam int CNT_W          = $clog2(BITS_PER_PIXEL);
	localparam int TICK_W         = 15;
	localparam int CFG_IDX_W      = 2;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH = 2'd0,
		REG_ZERO_LOW  = 2'd1,
		REG_ONE_HIGH  = 2'd2,
		REG_ONE_LOW   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] low_ticks;
		logic              bit_value;
		logic              pixel_done;
		logic              frame_done;
	} symbol_t;

	typedef struct packed {
		logic [BITS_PER_PIXEL-1:0] data;
		logic                      last;
	} word_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
	} timing_t;

	localparam logic [7:0] GREEN_CURVE [256] = '{
		8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd4, 8'd5,
		8'd6, 8'd7, 8'd7, 8'd8, 8'd9, 8'd10, 8'd10, 8'd11,
		8'd12, 8'd13, 8'd14, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18,
		8'd18, 8'd19, 8'd20, 8'd21, 8'd21, 8'd22, 8'd23, 8'd24,
		8'd25, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
		8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd36,
		8'd37, 8'd38, 8'd39, 8'd40, 8'd40, 8'd41, 8'd42, 8'd43,
		8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd47, 8'd48, 8'd49,
		8'd50, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd54, 8'd55,
		8'd56, 8'd57, 8'd58, 8'd58, 8'd59, 8'd60, 8'd61, 8'd61,
		8'd62, 8'd63, 8'd64, 8'd65, 8'd65, 8'd66, 8'd67, 8'd68,
		8'd69, 8'd69, 8'd70, 8'd71, 8'd72, 8'd72, 8'd73, 8'd74,
		8'd75, 8'd76, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd80,
		8'd81, 8'd82, 8'd83, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87,
		8'd87, 8'd88, 8'd89, 8'd90, 8'd90, 8'd91, 8'd92, 8'd93,
		8'd94, 8'd94, 8'd95, 8'd96, 8'd97, 8'd98, 8'd98, 8'd99,
		8'd100, 8'd101, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd105,
		8'd106, 8'd107, 8'd108, 8'd109, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd116, 8'd117, 8'd118,
		8'd119, 8'd120, 8'd120, 8'd121, 8'd122, 8'd123, 8'd123, 8'd124,
		8'd125, 8'd126, 8'd127, 8'd127, 8'd128, 8'd129, 8'd130, 8'd130,
		8'd131, 8'd132, 8'd133, 8'd134, 8'd134, 8'd135, 8'd136, 8'd137,
		8'd138, 8'd138, 8'd139, 8'd140, 8'd141, 8'd141, 8'd142, 8'd143,
		8'd144, 8'd145, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149, 8'd149,
		8'd150, 8'd151, 8'd152, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156,
		8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
		8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168,
		8'd169, 8'd170, 8'd170, 8'd171, 8'd172, 8'd173, 8'd174, 8'd174,
		8'd175, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180, 8'd181,
		8'd181, 8'd182, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187,
		8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193,
		8'd194, 8'd195, 8'd196, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200
	};

	localparam logic [7:0] BLUE_CURVE [256] = '{
		8'd0, 8'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd3, 8'd4,
		8'd5, 8'd5, 8'd6, 8'd6, 8'd7, 8'd8, 8'd8, 8'd9,
		8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd13, 8'd13, 8'd14,
		8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd18, 8'd18, 8'd19,
		8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd23, 8'd23, 8'd24,
		8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29,
		8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd33, 8'd34,
		8'd35, 8'd35, 8'd36, 8'd37, 8'd37, 8'd38, 8'd38, 8'd39,
		8'd40, 8'd40, 8'd41, 8'd42, 8'd42, 8'd43, 8'd43, 8'd44,
		8'd45, 8'd45, 8'd46, 8'd47, 8'd47, 8'd48, 8'd48, 8'd49,
		8'd50, 8'd50, 8'd51, 8'd52, 8'd52, 8'd53, 8'd53, 8'd54,
		8'd55, 8'd55, 8'd56, 8'd57, 8'd57, 8'd58, 8'd58, 8'd59,
		8'd60, 8'd60, 8'd61, 8'd62, 8'd62, 8'd63, 8'd64, 8'd64,
		8'd65, 8'd65, 8'd66, 8'd67, 8'd67, 8'd68, 8'd69, 8'd69,
		8'd70, 8'd70, 8'd71, 8'd72, 8'd72, 8'd73, 8'd74, 8'd74,
		8'd75, 8'd75, 8'd76, 8'd77, 8'd77, 8'd78, 8'd79, 8'd79,
		8'd80, 8'd80, 8'd81, 8'd82, 8'd82, 8'd83, 8'd84, 8'd84,
		8'd85, 8'd85, 8'd86, 8'd87, 8'd87, 8'd88, 8'd89, 8'd89,
		8'd90, 8'd90, 8'd91, 8'd92, 8'd92, 8'd93, 8'd94, 8'd94,
		8'd95, 8'd96, 8'd96, 8'd97, 8'd97, 8'd98, 8'd99, 8'd99,
		8'd100, 8'd101, 8'd101, 8'd102, 8'd102, 8'd103, 8'd104, 8'd104,
		8'd105, 8'd106, 8'd106, 8'd107, 8'd107, 8'd108, 8'd109, 8'd109,
		8'd110, 8'd111, 8'd111, 8'd112, 8'd112, 8'd113, 8'd114, 8'd114,
		8'd115, 8'd116, 8'd116, 8'd117, 8'd117, 8'd118, 8'd119, 8'd119,
		8'd120, 8'd121, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd124,
		8'd125, 8'd126, 8'd126, 8'd127, 8'd128, 8'd128, 8'd129, 8'd129,
		8'd130, 8'd131, 8'd131, 8'd132, 8'd133, 8'd133, 8'd134, 8'd134,
		8'd135, 8'd136, 8'd136, 8'd137, 8'd138, 8'd138, 8'd139, 8'd139,
		8'd140, 8'd141, 8'd141, 8'd142, 8'd143, 8'd143, 8'd144, 8'd144,
		8'd145, 8'd146, 8'd146, 8'd147, 8'd148, 8'd148, 8'd149, 8'd149,
		8'd150, 8'd151, 8'd151, 8'd152, 8'd153, 8'd153, 8'd154, 8'd154,
		8'd155, 8'd156, 8'd156, 8'd157, 8'd158, 8'd158, 8'd159, 8'd160
	};

endpackage

### hw/rtl/led_pixel_bit_timing_encoder_top.sv
// ----------------------------------------------------------------------------
// led_pixel_bit_timing_encoder_top
// Single-wire LED pixel encoder: one pixel in, 24 timed bit symbols out.
// ----------------------------------------------------------------------------
// Input: pixel is taken on a clock edge with push high and full low. Green and
// blue are corrected by fixed curves, red passes as is; the word is queued.
// Output: while empty is low, symbol holds the oldest bit symbol (green, red,
// blue, MSB first); pop high on an edge takes it. pixel_done marks the 24th
// symbol, frame_done the 24th symbol of a pixel flagged last_pixel.
// Timing: high and low tick counts come from the four timing registers,
// written through cfg_we / cfg_index / cfg_data; write them only while idle.
// Path: a pushed word passes the queue, the serializer's word register, then the result register.
// Throughput: one symbol per cycle while words are queued and pop is held,
// set by the serializer's shift; a two-word queue lets intake run ahead.
// Reset: queue and serializer empty, timing registers at 4/9/8/5 ticks.
// Stall: a held result freezes the serializer; the queue fills and full rises.
// ----------------------------------------------------------------------------
module led_pixel_bit_timing_encoder_top
	import lpbte_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  pixel_t               pixel,
	output logic                 empty,
	input  logic                 pop,
	output symbol_t              symbol,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	timing_t     timing_q;
	queue_stat_t q_stat;
	logic        q_push;
	logic        q_pop;
	word_t       q_wr_word;
	word_t       q_rd_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.zero_high <= TICK_W'(4);
			timing_q.zero_low  <= TICK_W'(9);
			timing_q.one_high  <= TICK_W'(8);
			timing_q.one_low   <= TICK_W'(5);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ZERO_HIGH: timing_q.zero_high <= cfg_data;
				REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data;
				REG_ONE_HIGH:  timing_q.one_high  <= cfg_data;
				REG_ONE_LOW:   timing_q.one_low   <= cfg_data;
				default: ;
			endcase
		end
	end

	lpbte_front u_front (
		.push   (push),
		.full   (full),
		.pixel  (pixel),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_word (q_wr_word)
	);

	lpbte_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_word (q_wr_word),
		.rd_en   (q_pop),
		.rd_word (q_rd_word),
		.stat    (q_stat)
	);

	lpbte_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.timing (timing_q),
		.q_stat (q_stat),
		.q_word (q_rd_word),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.symbol (symbol)
	);

endmodule

### hw/rtl/lpbte_front.sv
// ----------------------------------------------------------------------------
// lpbte_front
// Pixel intake: corrects green and blue and packs the 24-bit send word.
// ----------------------------------------------------------------------------
module lpbte_front
	import lpbte_pkg::*;
(
	input  logic        push,
	output logic        full,
	input  pixel_t      pixel,
	input  queue_stat_t q_stat,
	output logic        q_push,
	output word_t       q_word
);

	assign full   = q_stat.full;
	assign q_push = push && !q_stat.full;

	always_comb begin
		q_word.data = {GREEN_CURVE[pixel.green], pixel.red, BLUE_CURVE[pixel.blue]};
		q_word.last = pixel.last_pixel;
	end

endmodule

### hw/rtl/lpbte_queue.sv
// ----------------------------------------------------------------------------
// lpbte_queue
// Short word queue between pixel intake and the symbol serializer.
// ----------------------------------------------------------------------------
module lpbte_queue
	import lpbte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  word_t       wr_word,
	input  logic        rd_en,
	output word_t       rd_word,
	output queue_stat_t stat
);

	word_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign rd_word    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_word;
	end

endmodule

### hw/rtl/lpbte_back.sv
// ----------------------------------------------------------------------------
// lpbte_back
// Serializer: one bit symbol per cycle into the result register, unless held.
// ----------------------------------------------------------------------------
module lpbte_back
	import lpbte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  timing_t     timing,
	input  queue_stat_t q_stat,
	input  word_t       q_word,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output symbol_t     symbol
);

	logic [BITS_PER_PIXEL-1:0] word_q;
	logic                      last_q;
	logic [CNT_W-1:0]          count_q;
	logic                      busy_q;
	logic                      out_valid_q;
	symbol_t                   out_q;

	logic    emit;
	logic    final_bit;
	logic    load;
	logic    cur_bit;
	symbol_t sym;

	assign cur_bit   = word_q[BITS_PER_PIXEL-1];
	assign final_bit = count_q == CNT_W'(BITS_PER_PIXEL - 1);
	assign emit      = busy_q && (!out_valid_q || pop);
	assign load      = q_stat.valid && (!busy_q || (emit && final_bit));
	assign q_pop     = load;
	assign empty     = !out_valid_q;
	assign symbol    = out_q;

	always_comb begin
		sym.high_ticks = cur_bit ? timing.one_high : timing.zero_high;
		sym.low_ticks  = cur_bit ? timing.one_low : timing.zero_low;
		sym.bit_value  = cur_bit;
		sym.pixel_done = final_bit;
		sym.frame_done = final_bit && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (emit) begin
				count_q <= count_q + 1'b1;
				if (final_bit)
					busy_q <= 1'b0;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= q_word.data;
			last_q <= q_word.last;
		end else if (emit) begin
			word_q <= {word_q[BITS_PER_PIXEL-2:0], 1'b0};
		end
		if (emit)
			out_q <= sym;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> count_q <= CNT_W'(BITS_PER_PIXEL - 1))
		else $error("bit counter past end of pixel");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("queue read while empty");

	a_frame_on_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_done |-> out_q.pixel_done)
		else $error("frame end without pixel end");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("result register changed while stalled");

	a_reload_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && load |-> emit && final_bit)
		else $error("new word loaded before current pixel finished");

endmodule

### verif/led_pixel_bit_timing_encoder_top_test.sv
// ----------------------------------------------------------------------------
// led_pixel_bit_timing_encoder_top_test
// Self-checking bench for the LED pixel bit encoder. Pixels are pushed with
// random gaps and every symbol is popped with random stalls. Each accepted
// pixel is expanded into its 24 expected symbols, using the current timing
// registers and the color correction. Each popped symbol is compared field by
// field against the oldest expected one. The run covers directed corner
// pixels, extreme and random timing settings, random frames of pixels, and a
// long output stall that fills the queue.
// ----------------------------------------------------------------------------
module led_pixel_bit_timing_encoder_top_test;
	import lpbte_pkg::*;

	localparam int      PERIOD       = 10;
	localparam int      RESET_CYCLES = 8;
	localparam int      HOLD_CYCLES  = 400;
	localparam int      TAIL_CYCLES  = 8;
	localparam longint  RUN_LIMIT    = 64'd9_000_000;

	class symbol_scoreboard;
		localparam int MAX_PRINTS = 30;

		symbol_t pending[$];
		timing_t tm;
		int      errors;

		function new();
			errors = 0;
			tm.zero_high = 15'd4;
			tm.zero_low  = 15'd9;
			tm.one_high  = 15'd8;
			tm.one_low   = 15'd5;
		endfunction

		// green and blue curves are straight scalings to 200 and 160, floored
		function logic [7:0] green_corr(logic [7:0] v);
			return 8'((int'(v) * 200) / 255);
		endfunction

		function logic [7:0] blue_corr(logic [7:0] v);
			return 8'((int'(v) * 160) / 255);
		endfunction

		function void set_timing(cfg_reg_t idx, logic [TICK_W-1:0] v);
			case (idx)
				REG_ZERO_HIGH: tm.zero_high = v;
				REG_ZERO_LOW:  tm.zero_low  = v;
				REG_ONE_HIGH:  tm.one_high  = v;
				REG_ONE_LOW:   tm.one_low   = v;
				default: ;
			endcase
		endfunction

		function void note_pixel(pixel_t p);
			logic [BITS_PER_PIXEL-1:0] word;
			symbol_t                   s;
			logic                      b;
			word = {green_corr(p.green), p.red, blue_corr(p.blue)};
			for (int k = 0; k < BITS_PER_PIXEL; k++) begin
				b            = word[BITS_PER_PIXEL-1-k];
				s.high_ticks = b ? tm.one_high : tm.zero_high;
				s.low_ticks  = b ? tm.one_low : tm.zero_low;
				s.bit_value  = b;
				s.pixel_done = (k == BITS_PER_PIXEL - 1);
				s.frame_done = s.pixel_done && p.last_pixel;
				pending.push_back(s);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
		endtask

		task check_symbol(symbol_t got);
			symbol_t want;
			if (pending.size() == 0) begin
				report($sformatf("symbol %h with none outstanding", got));
				return;
			end
			want = pending.pop_front();
			if (got.high_ticks !== want.high_ticks)
				report($sformatf("high_ticks %0d, want %0d", got.high_ticks, want.high_ticks));
			if (got.low_ticks !== want.low_ticks)
				report($sformatf("low_ticks %0d, want %0d", got.low_ticks, want.low_ticks));
			if (got.bit_value !== want.bit_value)
				report($sformatf("bit_value %b, want %b", got.bit_value, want.bit_value));
			if (got.pixel_done !== want.pixel_done)
				report($sformatf("pixel_done %b, want %b", got.pixel_done, want.pixel_done));
			if (got.frame_done !== want.frame_done)
				report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	pixel_t               pixel;
	logic                 empty;
	logic                 pop;
	symbol_t              symbol;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	symbol_scoreboard sb = new();
	bit               send_idle;
	bit               pop_idle;
	bit               hold_request;

	led_pixel_bit_timing_encoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.symbol    (symbol),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [TICK_W-1:0] pick_tick();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return TICK_W'($urandom_range(0, (1 << TICK_W) - 1));
		endcase
	endfunction

	function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic l);
		pixel_t p;
		p.red        = r;
		p.green      = g;
		p.blue       = b;
		p.last_pixel = l;
		return p;
	endfunction

	task send_pixel(input pixel_t p, input int gap);
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		sb.note_pixel(p);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task load_timing(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
		input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol);
		cfg_reg_t          idx [4];
		logic [TICK_W-1:0] val [4];
		idx = '{REG_ZERO_HIGH, REG_ZERO_LOW, REG_ONE_HIGH, REG_ONE_LOW};
		val = '{zh, zl, oh, ol};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_timing(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				gap = pop_idle ? pick_gap() : 0;
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				pop <= 1'b1;
				@(posedge clk);
				if (!empty) sb.check_symbol(symbol);
			end
		end
	end

	initial begin : stimulus
		int count;
		int len;
		bit last;
		arst_n       = 1'b0;
		push         = 1'b0;
		pixel        = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_ZERO_HIGH;
		cfg_data     = '0;
		send_idle    = 1'b0;
		pop_idle     = 1'b0;
		hold_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner pixels at reset timing
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0), 0);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0), 0);
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0), 0);
		send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b1), 0);
		send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 1'b0), 0);
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 1'b0), 0);
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 1'b1), 0);
		send_pixel(make_pixel(8'h01, 8'h01, 8'h01, 1'b0), 0);
		send_pixel(make_pixel(8'h7F, 8'hCC, 8'h33, 1'b1), 0);
		drain();

		// extreme timing settings
		load_timing('0, '0, '0, '0);
		send_pixel(make_pixel(8'hA5, 8'h5A, 8'hC3, 1'b0), 0);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b1), 0);
		drain();
		load_timing('1, '1, '1, '1);
		send_pixel(make_pixel(8'h0F, 8'hF0, 8'h3C, 1'b1), 0);
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0), 0);
		drain();
		load_timing('1, '0, '0, '1);
		send_pixel(make_pixel(8'hAA, 8'hAA, 8'hAA, 1'b0), 0);
		send_pixel(make_pixel(8'h55, 8'h55, 8'h55, 1'b1), 0);
		drain();
		load_timing(15'h5555, 15'h2AAA, 15'h2AAA, 15'h5555);
		send_pixel(make_pixel(8'hF0, 8'h0F, 8'hF0, 1'b1), 0);
		send_pixel(make_pixel(8'h3C, 8'hC3, 8'h81, 1'b0), 0);
		drain();

		// hold the output long enough that the queue fills and stalls intake
		load_timing(15'd4, 15'd9, 15'd8, 15'd5);
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 11), 0);
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			load_timing(pick_tick(), pick_tick(), pick_tick(), pick_tick());
			send_idle = (ph % 2) == 1;
			pop_idle  = (ph % 3) != 0;
			count     = 0;
			while (count < 18) begin
				len = $urandom_range(1, 6);
				for (int j = 0; j < len; j++) begin
					last = (j == len - 1);
					if ($urandom_range(0, 9) == 0) last = ~last;
					send_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), last),
						send_idle ? pick_gap() : 0);
					count++;
				end
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### led_pixel_bit_timing_encoder_top.f
hw/rtl/lpbte_pkg.sv
hw/rtl/lpbte_front.sv
hw/rtl/lpbte_queue.sv
hw/rtl/lpbte_back.sv
hw/rtl/led_pixel_bit_timing_encoder_top.sv
verif/led_pixel_bit_timing_encoder_top_test.sv
